// ===== rtl/lbpe_pkg.sv =====
// Shared types, constants and helper functions of the LCD background pixel engine.
// Used by lbpe_vram and lcd_background_pixel_engine_top; depends on nothing else.
package lbpe_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int VRAM_ADDR_W = 13;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 40;

    // Defaults for the top-level parameters
    localparam int DEF_VRAM_DEPTH    = 8192;
    localparam int DEF_SCREEN_WIDTH  = 160;
    localparam int DEF_VISIBLE_LINES = 144;
    localparam int DEF_QUEUE_DEPTH   = 16;

    // Line timing
    localparam logic [8:0] SEARCH_DOTS = 9'd80;
    localparam logic [8:0] LINE_DOTS   = 9'd456;
    localparam logic [7:0] TOTAL_LINES = 8'd154;

    // VRAM offsets of the tile maps and of the signed tile block
    localparam logic [VRAM_ADDR_W-1:0] MAP_LOW_OFS   = 13'h1800;
    localparam logic [VRAM_ADDR_W-1:0] MAP_HIGH_OFS  = 13'h1C00;
    localparam logic [VRAM_ADDR_W-1:0] SIGNED_BASE   = 13'h1000;

    typedef enum logic [1:0] {
        PH_HBLANK   = 2'd0,
        PH_VBLANK   = 2'd1,
        PH_SEARCH   = 2'd2,
        PH_TRANSFER = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        FS_MAP  = 2'd0,
        FS_LOW  = 2'd1,
        FS_HIGH = 2'd2,
        FS_PUSH = 2'd3
    } fetch_step_t;

    // What the VRAM read issued on the previous cycle was for
    typedef enum logic [1:0] {
        PD_NONE = 2'd0,
        PD_MAP  = 2'd1,
        PD_LOW  = 2'd2,
        PD_HIGH = 2'd3
    } pend_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LCD_ENABLE    = 3'd0,
        CFG_BG_MAP_HIGH   = 3'd1,
        CFG_TILE_UNSIGNED = 3'd2,
        CFG_SCROLL_Y      = 3'd3,
        CFG_BG_PALETTE    = 3'd4,
        CFG_LY_COMPARE    = 3'd5
    } cfg_idx_t;

    // Read request from the fetcher to the VRAM
    typedef struct packed {
        logic                   en;
        logic [VRAM_ADDR_W-1:0] addr;
    } rd_req_t;

    // Gray level of a palette shade: 255 - 85 * shade
    function automatic logic [7:0] shade_level(input logic [1:0] shade);
        logic [7:0] lvl;
        unique case (shade)
            2'd0: lvl = 8'd255;
            2'd1: lvl = 8'd170;
            2'd2: lvl = 8'd85;
            2'd3: lvl = 8'd0;
            default: lvl = 8'd0;
        endcase
        return lvl;
    endfunction

endpackage

// ===== rtl/lbpe_vram.sv =====
// Tile VRAM of the background pixel engine: one write port, one registered read port.
// Depends on lbpe_pkg for the address width and the read request struct.
module lbpe_vram #(
    parameter int DEPTH = lbpe_pkg::DEF_VRAM_DEPTH
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [lbpe_pkg::VRAM_ADDR_W-1:0]  wr_addr,
    input  logic [lbpe_pkg::BYTE_W-1:0]       wr_data,
    input  lbpe_pkg::rd_req_t                 rd,
    output logic [lbpe_pkg::BYTE_W-1:0]       rd_data
);
    import lbpe_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(wr_addr)] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[AW'(rd.addr)];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lcd_background_pixel_engine_top.sv =====
// LCD background pixel engine: one beat in, one result beat out.
// A result is registered and shown in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless m_tready stalls; at most one read per tick.
// Reset (rst_n, asynchronous, active low) clears timing, fetcher, queue fill, flags.
// VRAM contents are undefined after reset and need no clearing pass.
// Depends on lbpe_pkg and lbpe_vram.
module lcd_background_pixel_engine_top #(
    parameter int VRAM_DEPTH    = lbpe_pkg::DEF_VRAM_DEPTH,
    parameter int SCREEN_WIDTH  = lbpe_pkg::DEF_SCREEN_WIDTH,
    parameter int VISIBLE_LINES = lbpe_pkg::DEF_VISIBLE_LINES,
    parameter int QUEUE_DEPTH   = lbpe_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [lbpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lbpe_pkg::BYTE_W-1:0]        cfg_data,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: vram_addr [12:0], vram_data [20:13], zero [23:21]
    input  logic [lbpe_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: mode [0]
    input  logic                               s_tuser,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: pixel_x [7:0], pixel_y [15:8], pixel_shade [23:16], lcd_mode [25:24],
    //          line [33:26], coincidence [34], vblank_request [35], zero [39:36]
    output logic [lbpe_pkg::OUT_DATA_W-1:0]    m_tdata,
    // m_tuser: pixel_valid [0]
    output logic                               m_tuser,
    // m_tlast: frame_done, the beat on which the line counter wraps to zero
    output logic                               m_tlast
);
    import lbpe_pkg::*;

    localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COL_W-1:0]  COL_END   = COL_W'(SCREEN_WIDTH);
    localparam logic [7:0]        VIS_END   = 8'(VISIBLE_LINES);
    localparam logic [FILL_W-1:0] FILL_EIGHT = FILL_W'(8);

    // Configuration registers
    logic       lcd_enable_reg;
    logic       bg_map_high_reg;
    logic       tile_unsigned_reg;
    logic [7:0] scroll_y_reg;
    logic [7:0] bg_palette_reg;
    logic [7:0] ly_compare_reg;

    // Timing and fetcher state
    phase_t            phase_reg, phase_next;
    phase_t            shown_reg, shown_next;
    logic [8:0]        dot_reg, dot_next;
    logic [7:0]        line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [1:0]        queue_reg [QUEUE_DEPTH];
    logic [1:0]        queue_next [QUEUE_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              toggle_reg, toggle_next;
    fetch_step_t       step_reg, step_next;
    logic [4:0]        tcol_reg, tcol_next;
    logic [7:0]        srow_reg, srow_next;
    logic [VRAM_ADDR_W-1:0] taddr_reg, taddr_next;
    logic              coin_reg, coin_next;
    logic              vblank_reg, vblank_next;

    // Tile bytes, captured from the registered VRAM read data as pend_reg names
    pend_t             pend_reg, pend_next;
    logic [7:0]        tnum_reg;
    logic [7:0]        plane_lo_reg;
    logic [7:0]        plane_hi_reg;

    // Result register
    logic              out_valid_reg;
    logic              pix_valid_reg, pix_valid_next;
    logic [7:0]        pix_x_reg, pix_x_next;
    logic [7:0]        pix_y_reg, pix_y_next;
    logic [7:0]        pix_shade_reg, pix_shade_next;
    logic              frame_done_reg, frame_done_next;

    logic              accept;
    logic              is_write;
    logic              is_tick;
    rd_req_t           rd_req;
    logic [7:0]        rd_data;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_write = accept && s_tuser;
    assign is_tick  = accept && !s_tuser && lcd_enable_reg;

    // Tile VRAM
    lbpe_vram #(
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .clk     (clk),
        .wr_en   (is_write),
        .wr_addr (s_tdata[VRAM_ADDR_W-1:0]),
        .wr_data (s_tdata[VRAM_ADDR_W +: BYTE_W]),
        .rd      (rd_req),
        .rd_data (rd_data)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcd_enable_reg    <= 1'b0;
            bg_map_high_reg   <= 1'b0;
            tile_unsigned_reg <= 1'b0;
            scroll_y_reg      <= '0;
            bg_palette_reg    <= '0;
            ly_compare_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LCD_ENABLE:    lcd_enable_reg    <= cfg_data[0];
                CFG_BG_MAP_HIGH:   bg_map_high_reg   <= cfg_data[0];
                CFG_TILE_UNSIGNED: tile_unsigned_reg <= cfg_data[0];
                CFG_SCROLL_Y:      scroll_y_reg      <= cfg_data;
                CFG_BG_PALETTE:    bg_palette_reg    <= cfg_data;
                CFG_LY_COMPARE:    ly_compare_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Next state of the dot timing, the fetcher and the pixel queue for one tick
    always_comb
    begin
        logic [1:0]             pix [8];
        logic [1:0]             mid [QUEUE_DEPTH];
        logic [2:0]             off;
        logic [1:0]             popped;
        logic [VRAM_ADDR_W-1:0] map_base;
        logic [VRAM_ADDR_W-1:0] tile_base;
        logic                   fetch_go;
        logic                   skip_coin;

        phase_next      = phase_reg;
        shown_next      = shown_reg;
        dot_next        = dot_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        fill_next       = fill_reg;
        toggle_next     = toggle_reg;
        step_next       = step_reg;
        tcol_next       = tcol_reg;
        srow_next       = srow_reg;
        taddr_next      = taddr_reg;
        coin_next       = coin_reg;
        vblank_next     = vblank_reg;
        pend_next       = PD_NONE;
        rd_req.en       = 1'b0;
        rd_req.addr     = '0;
        pix_valid_next  = 1'b0;
        pix_x_next      = '0;
        pix_y_next      = '0;
        pix_shade_next  = '0;
        frame_done_next = 1'b0;
        skip_coin       = 1'b0;
        fetch_go        = 1'b0;
        popped          = '0;
        off             = '0;
        map_base        = bg_map_high_reg ? MAP_HIGH_OFS : MAP_LOW_OFS;
        tile_base       = '0;
        for (int i = 0; i < 8; i++)
        begin
            pix[i] = {plane_hi_reg[i], plane_lo_reg[i]};
        end
        for (int j = 0; j < QUEUE_DEPTH; j++)
        begin
            mid[j]        = queue_reg[j];
            queue_next[j] = queue_reg[j];
        end

        if (is_tick)
        begin
            dot_next = dot_reg + 9'd1;
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    shown_next = PH_SEARCH;
                    if (dot_next >= SEARCH_DOTS)
                    begin
                        phase_next  = PH_TRANSFER;
                        tcol_next   = '0;
                        srow_next   = line_reg + scroll_y_reg;
                        toggle_next = 1'b0;
                        step_next   = FS_MAP;
                        fill_next   = '0;
                    end
                end
                PH_TRANSFER:
                begin
                    shown_next  = PH_TRANSFER;
                    toggle_next = !toggle_reg;
                    fetch_go    = !toggle_reg;
                    // Fetcher acts on every second dot
                    if (fetch_go)
                    begin
                        unique case (step_reg)
                            FS_MAP:
                            begin
                                rd_req.en   = 1'b1;
                                rd_req.addr = map_base
                                            + VRAM_ADDR_W'({srow_reg[7:3], tcol_reg});
                                pend_next   = PD_MAP;
                                step_next   = FS_LOW;
                            end
                            FS_LOW:
                            begin
                                if (tile_unsigned_reg || tnum_reg[7])
                                begin
                                    tile_base = VRAM_ADDR_W'({tnum_reg, 4'b0000});
                                end
                                else
                                begin
                                    tile_base = SIGNED_BASE
                                              + VRAM_ADDR_W'({tnum_reg, 4'b0000});
                                end
                                taddr_next  = tile_base
                                            + VRAM_ADDR_W'({srow_reg[2:0], 1'b0});
                                rd_req.en   = 1'b1;
                                rd_req.addr = taddr_next;
                                pend_next   = PD_LOW;
                                step_next   = FS_HIGH;
                            end
                            FS_HIGH:
                            begin
                                taddr_next  = taddr_reg + VRAM_ADDR_W'(1);
                                rd_req.en   = 1'b1;
                                rd_req.addr = taddr_next;
                                pend_next   = PD_HIGH;
                                step_next   = FS_PUSH;
                            end
                            FS_PUSH:
                            begin
                                // Push eight pixels, leftmost (bit 7) first
                                if (fill_reg <= FILL_EIGHT)
                                begin
                                    for (int j = 0; j < QUEUE_DEPTH; j++)
                                    begin
                                        if (FILL_W'(j) >= fill_reg &&
                                            FILL_W'(j) < fill_reg + FILL_EIGHT)
                                        begin
                                            off    = 3'(FILL_W'(j) - fill_reg);
                                            mid[j] = pix[3'd7 - off];
                                        end
                                    end
                                    fill_next = fill_reg + FILL_EIGHT;
                                    step_next = FS_MAP;
                                    tcol_next = tcol_reg + 5'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    // Pop one pixel while more than eight are held
                    if (fill_next > FILL_EIGHT)
                    begin
                        popped = mid[0];
                        for (int j = 0; j < QUEUE_DEPTH - 1; j++)
                        begin
                            queue_next[j] = mid[j + 1];
                        end
                        queue_next[QUEUE_DEPTH - 1] = mid[QUEUE_DEPTH - 1];
                        fill_next      = fill_next - FILL_W'(1);
                        pix_valid_next = 1'b1;
                        pix_x_next     = 8'(col_reg);
                        pix_y_next     = line_reg;
                        pix_shade_next = shade_level(bg_palette_reg[{popped, 1'b0} +: 2]);
                        col_next       = col_reg + COL_W'(1);
                        if (col_next >= COL_END)
                        begin
                            phase_next = PH_HBLANK;
                            col_next   = '0;
                        end
                    end
                    else
                    begin
                        for (int j = 0; j < QUEUE_DEPTH; j++)
                        begin
                            queue_next[j] = mid[j];
                        end
                        skip_coin = 1'b1;
                    end
                end
                PH_HBLANK:
                begin
                    shown_next = PH_HBLANK;
                    if (dot_next >= LINE_DOTS)
                    begin
                        line_next  = line_reg + 8'd1;
                        phase_next = PH_SEARCH;
                        col_next   = '0;
                        dot_next   = '0;
                        if (line_next >= VIS_END)
                        begin
                            phase_next  = PH_VBLANK;
                            vblank_next = 1'b1;
                        end
                    end
                end
                PH_VBLANK:
                begin
                    shown_next = PH_VBLANK;
                    if (dot_next >= LINE_DOTS)
                    begin
                        line_next = line_reg + 8'd1;
                        dot_next  = '0;
                        if (line_next >= TOTAL_LINES)
                        begin
                            phase_next      = PH_SEARCH;
                            line_next       = '0;
                            frame_done_next = 1'b1;
                            vblank_next     = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
            if (!skip_coin)
            begin
                coin_next = (line_next == ly_compare_reg);
            end
        end
    end

    // Timing, fetcher and queue registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SEARCH;
            shown_reg  <= PH_HBLANK;
            dot_reg    <= '0;
            line_reg   <= '0;
            col_reg    <= '0;
            fill_reg   <= '0;
            toggle_reg <= 1'b0;
            step_reg   <= FS_MAP;
            tcol_reg   <= '0;
            srow_reg   <= '0;
            taddr_reg  <= '0;
            coin_reg   <= 1'b0;
            vblank_reg <= 1'b0;
            pend_reg   <= PD_NONE;
        end
        else
        begin
            phase_reg  <= phase_next;
            shown_reg  <= shown_next;
            dot_reg    <= dot_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            fill_reg   <= fill_next;
            toggle_reg <= toggle_next;
            step_reg   <= step_next;
            tcol_reg   <= tcol_next;
            srow_reg   <= srow_next;
            taddr_reg  <= taddr_next;
            coin_reg   <= coin_next;
            vblank_reg <= vblank_next;
            pend_reg   <= pend_next;
        end
    end

    // Queue storage: payload only
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QUEUE_DEPTH; j++)
        begin
            queue_reg[j] <= queue_next[j];
        end
    end

    // Capture the VRAM byte read on the previous cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tnum_reg     <= '0;
            plane_lo_reg <= '0;
            plane_hi_reg <= '0;
        end
        else
        begin
            unique case (pend_reg)
                PD_MAP:
                begin
                    tnum_reg <= rd_data;
                end
                PD_LOW:
                begin
                    plane_lo_reg <= rd_data;
                    plane_hi_reg <= '0;
                end
                PD_HIGH:
                begin
                    plane_hi_reg <= rd_data;
                end
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_valid_reg  <= pix_valid_next;
            pix_x_reg      <= pix_x_next;
            pix_y_reg      <= pix_y_next;
            pix_shade_reg  <= pix_shade_next;
            frame_done_reg <= frame_done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = pix_valid_reg;
    assign m_tlast  = frame_done_reg;
    assign m_tdata  = {4'b0000, vblank_reg, coin_reg, line_reg,
                       shown_reg, pix_shade_reg, pix_y_reg, pix_x_reg};

`ifndef SYNTH
    // The queue never holds more than its depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("pixel queue overfilled");

    // A pixel is only emitted from the transfer phase
    a_pixel_in_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> shown_reg == PH_TRANSFER)
        else $error("pixel emitted outside transfer");

    // A frame wrap leaves the line counter at zero and the vblank flag clear
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && frame_done_reg |-> line_reg == 8'd0 && !vblank_reg)
        else $error("frame wrap left stale line state");

    // A VRAM read is followed by a capture of its byte
    a_read_capture: assert property (@(posedge clk) disable iff (!rst_n)
        rd_req.en |=> pend_reg != PD_NONE)
        else $error("VRAM read not captured");
`endif

endmodule
